### design/ssc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sine scroller package
// Shared constants, register codes and small lookup functions for the
// sine-wave text scroller slice generator.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // Default geometry of one glyph in the font image.
  localparam int GlyphWidthDef  = 48;
  localparam int GlyphHeightDef = 50;
  localparam int SliceWidthDef  = 4;

  // Payload widths fixed by the channel definitions.
  localparam int CharW = 8;
  localparam int CoordW = 11;
  localparam int AddrW = 17;

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 10;
  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMessageLen   = 2'd2;

  localparam int DimW = 10;
  localparam int LenW = 8;
  localparam logic [DimW-1:0] ScreenWidthRst  = 10'd320;
  localparam logic [DimW-1:0] ScreenHeightRst = 10'd240;

  // Scroll state. The position is signed and saturates at PosMax.
  localparam int PosW = 18;
  localparam logic signed [PosW-1:0] PosMax = 18'sd65535;
  localparam int ShiftW = 15;
  localparam logic [ShiftW-1:0] ShiftStep = 15'd5;

  localparam logic [CharW-1:0] CharSpace = 8'h20;

  localparam int DegW  = 9;
  localparam int WaveW = 6;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } glyph_pos_t;

  // First quadrant of trunc(25*sin(deg)), deg = 0..90.
  localparam logic [4:0] QuarterWave [0:90] = '{
    5'd0, 5'd0, 5'd0, 5'd1, 5'd1, 5'd2, 5'd2, 5'd3, 5'd3, 5'd3,
    5'd4, 5'd4, 5'd5, 5'd5, 5'd6, 5'd6, 5'd6, 5'd7, 5'd7, 5'd8,
    5'd8, 5'd8, 5'd9, 5'd9, 5'd10, 5'd10, 5'd10, 5'd11, 5'd11, 5'd12,
    5'd12, 5'd12, 5'd13, 5'd13, 5'd13, 5'd14, 5'd14, 5'd15, 5'd15, 5'd15,
    5'd16, 5'd16, 5'd16, 5'd17, 5'd17, 5'd17, 5'd17, 5'd18, 5'd18, 5'd18,
    5'd19, 5'd19, 5'd19, 5'd19, 5'd20, 5'd20, 5'd20, 5'd20, 5'd21, 5'd21,
    5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd22, 5'd23, 5'd23, 5'd23,
    5'd23, 5'd23, 5'd23, 5'd23, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24,
    5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24,
    5'd25
  };

  // Map a character byte to its cell in the 6-wide font grid. Anything
  // outside the font set is drawn as a period.
  function automatic glyph_pos_t glyph_of(input logic [CharW-1:0] ch);
    logic [5:0]  k;
    logic [11:0] prod;
    glyph_pos_t  g;
    if (ch >= 8'h61 && ch <= 8'h7a) begin
      k = 6'(ch - 8'h61);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      k = 6'(ch - 8'h30 + 8'd26);
    end else begin
      case (ch)
        8'h3f:   k = 6'd36;
        8'h21:   k = 6'd37;
        8'h28:   k = 6'd38;
        8'h29:   k = 6'd39;
        8'h2c:   k = 6'd41;
        default: k = 6'd40;
      endcase
    end
    // k / 6 for k below 42 is exactly (k * 43) >> 8.
    prod  = 12'(k) * 12'd43;
    g.row = prod[10:8];
    g.col = 3'(k - 6'(g.row) * 6'd6);
    return g;
  endfunction

  // Wave table index: (3*|x|/2) mod 360 for |x| up to 1023.
  function automatic logic [DegW-1:0] wave_deg(input logic [9:0] ax);
    logic [11:0] t;
    t = (12'(ax) + {1'b0, ax, 1'b0}) >> 1;
    if (t >= 12'd1440)      t = t - 12'd1440;
    else if (t >= 12'd1080) t = t - 12'd1080;
    else if (t >= 12'd720)  t = t - 12'd720;
    else if (t >= 12'd360)  t = t - 12'd360;
    return t[DegW-1:0];
  endfunction

  // Full-circle wave built from the first quadrant.
  function automatic logic signed [WaveW-1:0] wave_lut(input logic [DegW-1:0] deg);
    logic [6:0] idx;
    logic       neg;
    logic [4:0] mag;
    if (deg <= 9'd90) begin
      idx = deg[6:0];
      neg = 1'b0;
    end else if (deg <= 9'd180) begin
      idx = 7'(9'd180 - deg);
      neg = 1'b0;
    end else if (deg <= 9'd270) begin
      idx = 7'(deg - 9'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(9'd360 - deg);
      neg = 1'b1;
    end
    mag = (idx <= 7'd90) ? QuarterWave[idx] : 5'd0;
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage
`default_nettype wire

### design/ssc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel that carries one message character per item.
// ----------------------------------------------------------------------------
interface ssc_in_if;
  logic                        valid;
  logic                        ready;
  logic [ssc_pkg::CharW-1:0]   char_code;
  logic                        frame_end;

  modport source (output valid, output char_code, output frame_end, input ready);
  modport sink   (input valid, input char_code, input frame_end, output ready);
endinterface
`default_nettype wire

### design/ssc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slice channel
// Valid/ready channel that carries one visible glyph slice per item.
// ----------------------------------------------------------------------------
interface ssc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ssc_pkg::CoordW-1:0]  x_pos;
  logic signed [ssc_pkg::CoordW-1:0]  y_pos;
  logic [ssc_pkg::AddrW-1:0]          font_address;
  logic                               run_last;

  modport source (output valid, output x_pos, output y_pos, output font_address,
                  output run_last, input ready);
  modport sink   (input valid, input x_pos, input y_pos, input font_address,
                  input run_last, output ready);
endinterface
`default_nettype wire

### design/sine_wave_text_scroller_top.sv
`default_nettype none
// An accepted item is registered in the slice sequencer; its slices pass through stage B
// and the output register (stage C). The sequencer handles one slice per cycle unless the
// output stalls. A character gives GLYPH_WIDTH/SLICE_WIDTH slices (12 by default), fewer
// past the right edge, a space none. The next item is taken in a character's last step.
// Reset (asynchronous, active low) restores width 320, height 240, message length 0,
// scroll position 320 and frame shift 0, and empties the pipeline.
// ----------------------------------------------------------------------------
// Sine-wave text scroller top level
// Cuts each message character into vertical slices and emits screen x, a
// sine-wave y and a font image address for each slice that is on screen.
// ----------------------------------------------------------------------------
module sine_wave_text_scroller_top #(
  parameter int GLYPH_WIDTH  = ssc_pkg::GlyphWidthDef,
  parameter int GLYPH_HEIGHT = ssc_pkg::GlyphHeightDef,
  parameter int SLICE_WIDTH  = ssc_pkg::SliceWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ssc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ssc_pkg::CfgDataW-1:0]  cfg_data_i,
  ssc_in_if.sink                             char_i,
  ssc_out_if.source                          slice_o
);
  import ssc_pkg::*;

  // Offset of a slice inside its glyph; it always stays below GLYPH_WIDTH.
  localparam int OffW      = $clog2(GLYPH_WIDTH);
  // Distance in the font image from one glyph row to the next.
  localparam int RowStride = 6 * GLYPH_WIDTH * GLYPH_HEIGHT;
  localparam int LimW      = 17;
  localparam logic signed [PosW-1:0] NegSlice  = -(PosW'(SLICE_WIDTH));
  localparam logic signed [PosW-1:0] SliceStep = PosW'(SLICE_WIDTH);
  localparam logic signed [PosW-1:0] GlyphStep = PosW'(GLYPH_WIDTH);

  // Configuration registers.
  logic [DimW-1:0] sw_q, sh_q;
  logic [LenW-1:0] ml_q;

  // Scroll state.
  logic signed [PosW-1:0] pos_q, pos_d;
  logic [ShiftW-1:0]      shift_q, shift_d;

  // Slice sequencer: the character in work and where it stands.
  logic              busy_q, space_q, fend_q;
  logic [AddrW-1:0]  base_q;
  logic [OffW-1:0]   off_q;

  // Stage B holds a slice whose wave value is still to be looked up; stage C
  // is the output register.
  logic                     b_valid_q;
  logic signed [CoordW-1:0] bx_q;
  logic [DegW-1:0]          bdeg_q;
  logic [AddrW-1:0]         baddr_q;
  logic                     blast_q;

  logic                     c_valid_q;
  logic signed [CoordW-1:0] cx_q, cy_q;
  logic [AddrW-1:0]         caddr_q;
  logic                     clast_q;

  logic c_ready, b_ready;
  logic signed [PosW-1:0] sw_ext, pos_next_slice, pos_sat;
  logic stop, emit, step, last_col, final_step, run_last;
  logic in_acc;
  logic [LimW-1:0]   limit;
  logic [ShiftW-1:0] shift_eff;
  logic [9:0]        ax;
  glyph_pos_t        gpos;
  logic signed [WaveW-1:0] wave_b;

  assign c_ready = !c_valid_q || slice_o.ready;
  assign b_ready = !b_valid_q || c_ready;

  assign sw_ext         = $signed({{(PosW-DimW){1'b0}}, sw_q});
  assign pos_next_slice = pos_q + SliceStep;

  // A slice that starts right of the screen stops the character. A slice that
  // is entirely left of the screen is skipped but still advances the position.
  assign stop     = !space_q && (pos_q > sw_ext);
  assign emit     = busy_q && !space_q && !stop && (pos_q > NegSlice);
  assign step     = busy_q && (!emit || b_ready);
  assign last_col = (32'(off_q) + SLICE_WIDTH) >= GLYPH_WIDTH;
  assign final_step = space_q || stop || last_col;

  // Once a slice is visible every later one is too, so this slice is the last
  // one emitted exactly when the glyph ends here or the next slice stops it.
  assign run_last = last_col || (pos_next_slice > sw_ext);

  assign char_i.ready = !busy_q || (step && final_step);
  assign in_acc       = char_i.valid && char_i.ready;

  // Spaces advance by a glyph width and saturate; slices never come near it.
  always_comb begin
    pos_sat = pos_q + GlyphStep;
    if (pos_sat > PosMax) begin
      pos_sat = PosMax;
    end
  end

  // The frame shift wraps once the whole message has scrolled past.
  assign limit     = LimW'(32'(ml_q) * GLYPH_WIDTH + 32'(sw_q));
  assign shift_eff = (LimW'(shift_q) > limit) ? '0 : shift_q;

  always_comb begin
    pos_d   = pos_q;
    shift_d = shift_q;
    if (step) begin
      if (final_step && fend_q) begin
        pos_d   = sw_ext - $signed({{(PosW-ShiftW){1'b0}}, shift_eff});
        shift_d = shift_eff + ShiftStep;
      end else if (space_q) begin
        pos_d = pos_sat;
      end else if (!stop) begin
        pos_d = pos_next_slice;
      end
    end
    if (cfg_we_i && cfg_idx_i == CfgScreenWidth) begin
      pos_d = $signed({{(PosW-DimW){1'b0}}, cfg_data_i});
    end
  end

  assign ax   = pos_q[PosW-1] ? 10'(-pos_q) : pos_q[9:0];
  assign gpos = glyph_of(char_i.char_code);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q    <= ScreenWidthRst;
      sh_q    <= ScreenHeightRst;
      ml_q    <= '0;
      pos_q   <= $signed({{(PosW-DimW){1'b0}}, ScreenWidthRst});
      shift_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      shift_q <= shift_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgScreenWidth:  sw_q <= cfg_data_i[DimW-1:0];
          CfgScreenHeight: sh_q <= cfg_data_i[DimW-1:0];
          CfgMessageLen:   ml_q <= cfg_data_i[LenW-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (step && final_step) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Character context; loaded on accept, walked one slice per step.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      space_q <= (char_i.char_code == CharSpace);
      fend_q  <= char_i.frame_end;
      base_q  <= AddrW'(32'(gpos.row) * RowStride + 32'(gpos.col) * GLYPH_WIDTH);
      off_q   <= '0;
    end else if (step && !final_step) begin
      off_q <= OffW'(32'(off_q) + SLICE_WIDTH);
    end
  end

  // Slice pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (emit && step) begin
        b_valid_q <= 1'b1;
      end else if (c_ready) begin
        b_valid_q <= 1'b0;
      end
      if (b_valid_q && c_ready) begin
        c_valid_q <= 1'b1;
      end else if (slice_o.ready) begin
        c_valid_q <= 1'b0;
      end
    end
  end

  assign wave_b = wave_lut(bdeg_q);

  // Slice payload. The wave table is read on the way into the output register.
  always_ff @(posedge clk_i) begin
    if (emit && step) begin
      bx_q    <= pos_q[CoordW-1:0];
      bdeg_q  <= wave_deg(ax);
      baddr_q <= AddrW'(32'(base_q) + 32'(off_q));
      blast_q <= run_last;
    end
    if (b_valid_q && c_ready) begin
      cx_q    <= bx_q;
      cy_q    <= $signed({2'b00, sh_q[DimW-1:1]}) + {{(CoordW-WaveW){wave_b[WaveW-1]}}, wave_b};
      caddr_q <= baddr_q;
      clast_q <= blast_q;
    end
  end

  assign slice_o.valid        = c_valid_q;
  assign slice_o.x_pos        = cx_q;
  assign slice_o.y_pos        = cy_q;
  assign slice_o.font_address = caddr_q;
  assign slice_o.run_last     = clast_q;

`ifndef SYNTHESIS
  // Only slices that lie on screen reach the output register.
  a_slice_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q |-> (cx_q > -($signed(CoordW'(SLICE_WIDTH))))
                  && (cx_q <= $signed({1'b0, sw_q})))
    else $error("slice outside the visible range");

  // The position never goes above its saturation limit.
  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosMax)
    else $error("scroll position above its limit");

  // A stalled stage B slice keeps its payload while stage C cannot take it.
  a_stage_b_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !c_ready |=> b_valid_q && $stable(bx_q) && $stable(baddr_q))
    else $error("stage B slice lost under stall");

  // The slice offset stays inside the glyph while a character is in work.
  a_offset_in_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (32'(off_q) < GLYPH_WIDTH))
    else $error("slice offset beyond glyph width");
`endif

endmodule
`default_nettype wire
